>>> hdl/cfk_pkg.sv
// cfk_pkg: shared types and constants of the 3x3 fixed kernel filter
// no dependencies

package cfk_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int GEO_W      = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int ACC_W      = 13;
  localparam int RECIP_W    = 14;
  localparam int PROD_W     = 26;
  localparam int QUOT_LSB   = 16;

  localparam logic [GEO_W-1:0] GEO_RESET = 11'd1024;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // reciprocals scaled by 2**16, exact over the sum ranges in use
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = 14'd10923;
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = 14'd7282;

  // window taps, row major
  localparam int W_TL = 0;
  localparam int W_TC = 1;
  localparam int W_TR = 2;
  localparam int W_ML = 3;
  localparam int W_MC = 4;
  localparam int W_MR = 5;
  localparam int W_BL = 6;
  localparam int W_BC = 7;
  localparam int W_BR = 8;

  typedef enum logic [1:0] {
    MODE_EDGE   = 2'd0,
    MODE_GAUSS  = 2'd1,
    MODE_EMBOSS = 2'd2,
    MODE_BOX    = 2'd3
  } kernel_mode_e;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [POS_W-1:0]      orow;
    logic [POS_W-1:0]      ocol;
    logic                  fend;
  } cfk_item_t;

endpackage

>>> hdl/cfk_front.sv
// cfk_front: position counters, two line buffers and the 3x3 window
// classifies each pixel as border or interior and pushes interior windows
// depends on cfk_pkg

module cfk_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     pixel_i,
  input  logic                           geo_restart_i,
  input  logic [10:0]                    image_width_i,
  input  logic [10:0]                    image_height_i,
  input  logic                           q_ready_i,
  output logic                           push_o,
  output cfk_pkg::cfk_item_t             item_o
);
  import cfk_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int CMPW = (WW > GEO_W) ? WW : GEO_W;

  logic [CMPW-1:0]  width_ext;
  logic [WW-1:0]    w_use;
  logic [GEO_W-1:0] h_use;
  logic [CW-1:0]    col_q, col_d, c_eff, ocol_full;
  logic [ROW_W-1:0] row_q, row_d, r_eff;
  logic             last_col, last_row, interior, accept;

  logic             a_valid_q, a_valid_d, a_adv;
  logic [CW-1:0]    a_col_q;
  logic [PIX_W-1:0] a_pix_q;
  logic             a_int_q;
  logic [POS_W-1:0] a_orow_q, a_ocol_q;
  logic             a_fend_q;

  logic [PIX_W-1:0] line0 [MAX_WIDTH];
  logic [PIX_W-1:0] line1 [MAX_WIDTH];
  logic [PIX_W-1:0] mid_rd_q, top_rd_q;

  logic [8:0][PIX_W-1:0] win_q, win_d;

  // geometry in use
  always_comb begin
    width_ext = CMPW'(image_width_i);
    if (width_ext < CMPW'(3)) begin
      w_use = WW'(3);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(width_ext);
    end
    if (image_height_i < 11'd3) begin
      h_use = 11'd3;
    end else if (image_height_i > GEO_W'(MAX_HEIGHT)) begin
      h_use = GEO_W'(MAX_HEIGHT);
    end else begin
      h_use = image_height_i;
    end
  end

  // position of the incoming pixel
  always_comb begin
    if (WW'(col_q) >= w_use) begin
      c_eff = CW'(w_use - WW'(1));
    end else begin
      c_eff = col_q;
    end
    if (GEO_W'(row_q) >= h_use) begin
      r_eff = ROW_W'(h_use - 11'd1);
    end else begin
      r_eff = row_q;
    end
    last_col  = (WW'(c_eff) + WW'(1)) >= w_use;
    last_row  = (GEO_W'(r_eff) + 11'd1) >= h_use;
    interior  = (r_eff >= ROW_W'(2)) && (c_eff >= CW'(2));
    ocol_full = c_eff - CW'(1);
  end

  assign a_adv      = a_valid_q && (!a_int_q || q_ready_i);
  assign in_stall_o = a_valid_q && !a_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geo_restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_d = c_eff + CW'(1);
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_col_q  <= c_eff;
      a_pix_q  <= pixel_i;
      a_int_q  <= interior;
      a_orow_q <= POS_W'(r_eff - ROW_W'(1));
      a_ocol_q <= POS_W'(ocol_full);
      a_fend_q <= last_row && last_col;
    end
  end

  // newest row buffer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q     <= line0[c_eff];
      line0[c_eff] <= pixel_i;
    end
  end

  // older row buffer, filled from the newest row's read value when the held pixel advances
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= line1[c_eff];
    end
    if (a_adv) begin
      line1[a_col_q] <= mid_rd_q;
    end
  end

  always_comb begin
    win_d       = win_q;
    win_d[W_TL] = win_q[W_TC];
    win_d[W_TC] = win_q[W_TR];
    win_d[W_TR] = top_rd_q;
    win_d[W_ML] = win_q[W_MC];
    win_d[W_MC] = win_q[W_MR];
    win_d[W_MR] = mid_rd_q;
    win_d[W_BL] = win_q[W_BC];
    win_d[W_BC] = win_q[W_BR];
    win_d[W_BR] = a_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (a_adv) begin
      win_q <= win_d;
    end
  end

  assign push_o      = a_adv && a_int_q;
  assign item_o.win  = win_d;
  assign item_o.orow = a_orow_q;
  assign item_o.ocol = a_ocol_q;
  assign item_o.fend = a_fend_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_use)
    else $error("column counter beyond row width");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_int_q && !q_ready_i))
    else $error("input stalled without a full queue");

endmodule

>>> hdl/cfk_queue.sv
// cfk_queue: two entry queue of interior windows between front and back
// depends on cfk_pkg

module cfk_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfk_pkg::cfk_item_t push_item_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output cfk_pkg::cfk_item_t pop_item_o
);
  import cfk_pkg::*;

  cfk_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");

endmodule

>>> hdl/cfk_back.sv
// cfk_back: kernel sums, scaling and clamping, registered result
// depends on cfk_pkg

module cfk_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  cfk_pkg::cfk_item_t         item_i,
  output logic                       pop_o,
  input  cfk_pkg::kernel_mode_e      mode_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 value_o,
  output logic [9:0]                 out_row_o,
  output logic [9:0]                 out_col_o,
  output logic                       frame_end_o
);
  import cfk_pkg::*;

  logic signed [ACC_W-1:0] px [9];
  logic signed [ACC_W-1:0] acc_d;

  logic                    s1_valid_q, s1_ready, s2_ready;
  logic signed [ACC_W-1:0] s1_acc_q;
  kernel_mode_e            s1_mode_q;
  logic [POS_W-1:0]        s1_orow_q, s1_ocol_q;
  logic                    s1_fend_q;

  logic [RECIP_W-1:0]      recip;
  logic [PROD_W-1:0]       prod;
  logic [PIX_W-1:0]        value_d;

  logic                    out_valid_q;
  logic [PIX_W-1:0]        value_q;
  logic [POS_W-1:0]        orow_q, ocol_q;
  logic                    fend_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      px[i] = $signed({5'b0, item_i.win[i]});
    end
  end

  always_comb begin
    case (mode_i)
      MODE_EDGE: begin
        acc_d = px[W_BL] + (px[W_BC] <<< 1) + px[W_BR]
              - px[W_TL] - (px[W_TC] <<< 1) - px[W_TR];
      end
      MODE_GAUSS: begin
        acc_d = px[W_TC] + px[W_ML] + px[W_MR] + px[W_BC] + (px[W_MC] <<< 1);
      end
      MODE_EMBOSS: begin
        acc_d = px[W_TL] + px[W_TC] - px[W_TR] + px[W_ML] + px[W_MC]
              - px[W_MR] + px[W_BL] - px[W_BC] - px[W_BR];
      end
      default: begin
        acc_d = px[W_TL] + px[W_TC] + px[W_TR] + px[W_ML] + px[W_MC]
              + px[W_MR] + px[W_BL] + px[W_BC] + px[W_BR];
      end
    endcase
  end

  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_acc_q  <= acc_d;
      s1_mode_q <= mode_i;
      s1_orow_q <= item_i.orow;
      s1_ocol_q <= item_i.ocol;
      s1_fend_q <= item_i.fend;
    end
  end

  // gauss sum over six and box sum over nine share one multiplier
  assign recip = (s1_mode_q == MODE_GAUSS) ? RECIP_DIV6 : RECIP_DIV9;
  assign prod  = PROD_W'(unsigned'(s1_acc_q[ACC_W-2:0])) * PROD_W'(recip);

  always_comb begin
    case (s1_mode_q)
      MODE_GAUSS, MODE_BOX: begin
        value_d = prod[QUOT_LSB +: PIX_W];
      end
      default: begin
        if (s1_acc_q < 0) begin
          value_d = '0;
        end else if (s1_acc_q > ACC_W'(255)) begin
          value_d = 8'd255;
        end else begin
          value_d = s1_acc_q[PIX_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      value_q <= value_d;
      orow_q  <= s1_orow_q;
      ocol_q  <= s1_ocol_q;
      fend_q  <= s1_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign frame_end_o = fend_q;

endmodule

>>> hdl/conv3x3_fixed_kernel_filter.sv
// conv3x3_fixed_kernel_filter: top level, configuration registers and the
// front, queue and back parts; depends on cfk_pkg, cfk_front, cfk_queue, cfk_back
// throughput: one pixel per cycle while the input is not stalled; each pixel reads both line buffers
// path: a pixel is held in the front's input stage, then goes through the queue and the back's sum and output registers
// reset: counters, window, queue and pipeline valids clear, mode 3, 1024x1024
// line buffers are not cleared and need no clearing pass after reset

module conv3x3_fixed_kernel_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  value_o,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import cfk_pkg::*;

  kernel_mode_e     mode_q;
  logic [GEO_W-1:0] width_q, height_q;
  logic             cfg_wr, geo_restart;

  logic             push, q_ready, q_valid, pop;
  cfk_item_t        push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign geo_restart = cfg_wr && (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOX;
      width_q  <= GEO_RESET;
      height_q <= GEO_RESET;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= kernel_mode_e'(cfg_data_i[1:0]);
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cfk_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .geo_restart_i  (geo_restart),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .q_ready_i      (q_ready),
    .push_o         (push),
    .item_o         (push_item)
  );

  cfk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  cfk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

endmodule
